// ----- rtl/tiny_register_machine_step_assert.svh -----
// Assertion macros for the register machine step block.
`ifndef TINY_REGISTER_MACHINE_STEP_ASSERT_SVH
`define TINY_REGISTER_MACHINE_STEP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define TRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trm: implication check failed");
// Next-cycle implication.
`define TRM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trm: next-cycle check failed");
`else
`define TRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TRM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/trm_pkg.sv -----
`default_nettype none

package trm_pkg;

    localparam int PROGRAM_DEPTH_DEF  = 256;
    localparam int REGISTER_COUNT_DEF = 8;

    localparam int KIND_W   = 4;
    localparam int RIDX_W   = 3;
    localparam int DATA_W   = 32;
    localparam int TARGET_W = 8;
    localparam int NPC_W    = 9;

    // instruction kinds
    localparam logic [KIND_W-1:0] K_END  = 4'd0;
    localparam logic [KIND_W-1:0] K_MOVE = 4'd1;
    localparam logic [KIND_W-1:0] K_ADD  = 4'd2;
    localparam logic [KIND_W-1:0] K_SUB  = 4'd3;
    localparam logic [KIND_W-1:0] K_CMP  = 4'd4;
    localparam logic [KIND_W-1:0] K_BNE  = 4'd5;
    localparam logic [KIND_W-1:0] K_BEQ  = 4'd6;
    localparam logic [KIND_W-1:0] K_BLT  = 4'd7;
    localparam logic [KIND_W-1:0] K_BGE  = 4'd8;
    localparam logic [KIND_W-1:0] K_JMP  = 4'd9;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic [RIDX_W-1:0]          dest_reg;
        logic                       src_is_reg;
        logic [RIDX_W-1:0]          src_reg;
        logic signed [DATA_W-1:0]   immediate;
        logic [TARGET_W-1:0]        target;
    } t_trm_instr;

    typedef struct packed {
        logic [NPC_W-1:0]           next_pc;
        logic                       halted;
        logic                       reg_written;
        logic [RIDX_W-1:0]          written_reg;
        logic signed [DATA_W-1:0]   written_value;
        logic                       zero_flag;
        logic                       less_flag;
    } t_trm_result;

endpackage

`default_nettype wire

// ----- rtl/trm_stream_if.sv -----
`default_nettype none

interface trm_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/tiny_register_machine_step.sv -----
// Stages: two, input and output; a word moves on when the output stage is free or drains.
// Throughput: one instruction word per cycle while results are taken; the loop setting it
//   is register-file read, single add/subtract/compare and write-back, closed by a bypass.
// Reset: synchronous, active low; clears the stage valids, program counter, flags,
//   halt and the per-register valid bits (every register then reads as zero).
`default_nettype none

`include "tiny_register_machine_step_assert.svh"

module tiny_register_machine_step #(
    parameter int PROGRAM_DEPTH  = trm_pkg::PROGRAM_DEPTH_DEF,
    parameter int REGISTER_COUNT = trm_pkg::REGISTER_COUNT_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    trm_stream_if.sink   i_instr,
    trm_stream_if.source o_result
);

    // Counter must hold PROGRAM_DEPTH itself and any 8-bit branch target.
    localparam int PC_W = ($clog2(PROGRAM_DEPTH + 1) > trm_pkg::TARGET_W) ?
                          $clog2(PROGRAM_DEPTH + 1) : trm_pkg::TARGET_W;
    localparam int REG_IDX_W = $clog2(REGISTER_COUNT);
    localparam logic [PC_W-1:0] DEPTH_PC = PC_W'(PROGRAM_DEPTH);

    // ------------------------------------------------------------------
    // Handshake: input stage holds one word, output stage holds one result.
    // The input stage advances whenever the output stage is free or drains.
    // ------------------------------------------------------------------
    logic                  r_in_valid;
    trm_pkg::t_trm_instr   r_in;
    logic                  r_out_valid;
    trm_pkg::t_trm_result  r_out;

    logic in_fire;
    logic advance;

    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_instr.ready  = !r_in_valid || advance;
    assign in_fire        = i_instr.valid && i_instr.ready;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    // ------------------------------------------------------------------
    // Architectural state
    // ------------------------------------------------------------------
    logic [PC_W-1:0]            r_pc;
    logic                       r_stopped;
    logic                       r_eq;
    logic                       r_lt;

    // Register file: payload array without reset, valid bits with reset.
    logic [trm_pkg::DATA_W-1:0] r_regs [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0]  r_reg_vld;

    // Registered read ports, captured when the word enters the input stage.
    logic [trm_pkg::DATA_W-1:0] r_a_mem;
    logic [trm_pkg::DATA_W-1:0] r_b_mem;
    logic                       r_a_ok;
    logic                       r_b_ok;
    logic                       r_a_byp;
    logic                       r_b_byp;
    logic [trm_pkg::DATA_W-1:0] r_byp_val;

    // ------------------------------------------------------------------
    // Execute (between input stage and output stage)
    // ------------------------------------------------------------------
    logic [trm_pkg::DATA_W-1:0] a_val;
    logic [trm_pkg::DATA_W-1:0] b_val;
    logic [trm_pkg::DATA_W-1:0] alu_val;
    logic                       do_wr;
    logic                       taken;
    logic                       dst_in_rng;
    logic                       wr_en;
    logic [REG_IDX_W-1:0]       wr_idx;
    logic [PC_W-1:0]            n_pc;
    logic                       n_stopped;
    logic                       n_eq;
    logic                       n_lt;

    // Select the operand source: bypassed write, stored value, or zero for
    // an unwritten or out-of-range register.
    assign a_val = r_a_byp ? r_byp_val : (r_a_ok ? r_a_mem : '0);
    assign b_val = r_in.src_is_reg ?
                   (r_b_byp ? r_byp_val : (r_b_ok ? r_b_mem : '0)) :
                   r_in.immediate;

    assign dst_in_rng = int'(r_in.dest_reg) < REGISTER_COUNT;
    assign wr_idx     = REG_IDX_W'(r_in.dest_reg);

    always_comb begin
        alu_val   = '0;
        do_wr     = 1'b0;
        taken     = 1'b0;
        n_pc      = r_pc;
        n_stopped = r_stopped;
        n_eq      = r_eq;
        n_lt      = r_lt;
        if (!r_stopped) begin
            case (r_in.kind)
                trm_pkg::K_END: begin
                    n_stopped = 1'b1;
                end
                trm_pkg::K_MOVE: begin
                    alu_val = b_val;
                    do_wr   = 1'b1;
                end
                trm_pkg::K_ADD: begin
                    alu_val = a_val + b_val;
                    do_wr   = 1'b1;
                end
                trm_pkg::K_SUB: begin
                    alu_val = a_val - b_val;
                    do_wr   = 1'b1;
                end
                trm_pkg::K_CMP: begin
                    n_eq = (a_val == b_val);
                    n_lt = ($signed(a_val) < $signed(b_val));
                end
                trm_pkg::K_BNE: taken = !r_eq;
                trm_pkg::K_BEQ: taken = r_eq;
                trm_pkg::K_BLT: taken = r_lt;
                trm_pkg::K_BGE: taken = !r_lt;
                trm_pkg::K_JMP: taken = 1'b1;
                default: ;
            endcase
            // End keeps the counter; everything else advances or branches,
            // and running off the end of the program halts for good.
            if (r_in.kind != trm_pkg::K_END) begin
                n_pc = taken ? PC_W'(r_in.target) : r_pc + PC_W'(1);
                if (n_pc >= DEPTH_PC) begin
                    n_stopped = 1'b1;
                end
            end
        end
    end

    // Drop writes aimed past the last register.
    assign wr_en = advance && do_wr && dst_in_rng;

    // ------------------------------------------------------------------
    // Input stage with register-file read
    // ------------------------------------------------------------------
    logic a_rd_in_rng;
    logic b_rd_in_rng;
    logic [REG_IDX_W-1:0] a_rd_idx;
    logic [REG_IDX_W-1:0] b_rd_idx;

    assign a_rd_in_rng = int'(i_instr.data.dest_reg) < REGISTER_COUNT;
    assign b_rd_in_rng = int'(i_instr.data.src_reg) < REGISTER_COUNT;
    assign a_rd_idx    = REG_IDX_W'(i_instr.data.dest_reg);
    assign b_rd_idx    = REG_IDX_W'(i_instr.data.src_reg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Capture the word and its operands; forward the write that retires at
    // this same edge so the next word sees it.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in      <= i_instr.data;
            r_a_mem   <= r_regs[a_rd_idx];
            r_b_mem   <= r_regs[b_rd_idx];
            r_a_ok    <= a_rd_in_rng && r_reg_vld[a_rd_idx];
            r_b_ok    <= b_rd_in_rng && r_reg_vld[b_rd_idx];
            r_a_byp   <= wr_en && (i_instr.data.dest_reg == r_in.dest_reg);
            r_b_byp   <= wr_en && (i_instr.data.src_reg == r_in.dest_reg);
            r_byp_val <= alu_val;
        end
    end

    // Register-file write port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_regs[wr_idx] <= alu_val;
        end
    end

    // ------------------------------------------------------------------
    // State update and output stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_stopped   <= 1'b0;
            r_eq        <= 1'b0;
            r_lt        <= 1'b0;
            r_reg_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_pc        <= n_pc;
                r_stopped   <= n_stopped;
                r_eq        <= n_eq;
                r_lt        <= n_lt;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (wr_en) begin
                r_reg_vld[wr_idx] <= 1'b1;
            end
        end
    end

    // Result payload; a dropped or absent write reports index and value zero.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.next_pc       <= trm_pkg::NPC_W'(n_pc);
            r_out.halted        <= n_stopped;
            r_out.reg_written   <= wr_en;
            r_out.written_reg   <= wr_en ? r_in.dest_reg : '0;
            r_out.written_value <= wr_en ? alu_val : '0;
            r_out.zero_flag     <= n_eq;
            r_out.less_flag     <= n_lt;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TRM_ASSERT_NXT(a_halt_sticky, i_clk, i_rst_n, r_stopped, r_stopped)
    `TRM_ASSERT_IMP(a_halt_no_write, i_clk, i_rst_n, advance && r_stopped, !wr_en)
    `TRM_ASSERT_IMP(a_pc_in_program, i_clk, i_rst_n, !r_stopped, r_pc < DEPTH_PC)

endmodule

`default_nettype wire

// ----- test/tiny_register_machine_step_tb.sv -----
`timescale 1ns / 1ps

module tiny_register_machine_step_tb;
    import trm_pkg::*;

    localparam int PROGRAM_DEPTH  = PROGRAM_DEPTH_DEF;
    localparam int REGISTER_COUNT = REGISTER_COUNT_DEF;

    // Kinds above jump decode to nothing and just advance the counter.
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 4'd10;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 4'd15;

    // Counter level at which the stimulus forces a jump back, so the machine
    // only runs off the end of the program when the closing phase asks it to.
    localparam int PC_WRAP_LEVEL = 240;

    localparam int RANDOM_WORDS  = 800;
    localparam int STEADY_WORDS  = 100;
    localparam int REPORT_LIMIT  = 10;

    // Shadow of the machine: registers, counter, flags and halt, plus the
    // queue of result words still owed by the block.
    class machine_shadow;
        logic [DATA_W-1:0] regs [REGISTER_COUNT];
        int unsigned       pc;
        bit                eq_flag;
        bit                lt_flag;
        bit                stopped;
        t_trm_result       owed_results[$];
        int                mismatches;

        function new();
            foreach (regs[i]) regs[i] = '0;
            pc         = 0;
            eq_flag    = 1'b0;
            lt_flag    = 1'b0;
            stopped    = 1'b0;
            mismatches = 0;
        endfunction

        function logic [DATA_W-1:0] read_reg(logic [RIDX_W-1:0] idx);
            if (int'(idx) < REGISTER_COUNT) return regs[idx];
            return '0;
        endfunction

        // Execute one accepted instruction word and queue the result it owes.
        function void note_instr(t_trm_instr w);
            t_trm_result       r;
            logic [DATA_W-1:0] a;
            logic [DATA_W-1:0] b;
            logic [DATA_W-1:0] wval;
            int unsigned       nxt;
            bit                take;
            bit                wr;
            r = '0;
            if (!stopped) begin
                a    = read_reg(w.dest_reg);
                b    = w.src_is_reg ? read_reg(w.src_reg) : w.immediate;
                nxt  = pc + 1;
                take = 1'b0;
                wr   = 1'b0;
                wval = '0;
                case (w.kind)
                    K_END: begin
                        stopped = 1'b1;
                        nxt     = pc;
                    end
                    K_MOVE: begin
                        wval = b;
                        wr   = 1'b1;
                    end
                    K_ADD: begin
                        wval = a + b;
                        wr   = 1'b1;
                    end
                    K_SUB: begin
                        wval = a - b;
                        wr   = 1'b1;
                    end
                    K_CMP: begin
                        eq_flag = (a == b);
                        lt_flag = ($signed(a) < $signed(b));
                    end
                    K_BNE: take = !eq_flag;
                    K_BEQ: take = eq_flag;
                    K_BLT: take = lt_flag;
                    K_BGE: take = !lt_flag;
                    K_JMP: take = 1'b1;
                    default: ;
                endcase
                if (wr && int'(w.dest_reg) < REGISTER_COUNT) begin
                    regs[w.dest_reg] = wval;
                    r.reg_written    = 1'b1;
                    r.written_reg    = w.dest_reg;
                    r.written_value  = wval;
                end
                if (take) nxt = int'(w.target);
                if (!stopped) begin
                    pc = nxt;
                    if (pc >= PROGRAM_DEPTH) stopped = 1'b1;
                end
            end
            r.next_pc   = NPC_W'(pc);
            r.halted    = stopped;
            r.zero_flag = eq_flag;
            r.less_flag = lt_flag;
            owed_results.push_back(r);
        endfunction

        // Compare one accepted result word against the oldest owed one.
        function void check_result(t_trm_result got);
            t_trm_result exp;
            bit          bad;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: result word with nothing owed: pc=%0d halted=%0b",
                             got.next_pc, got.halted);
                return;
            end
            exp = owed_results.pop_front();
            bad = (got.next_pc       !== exp.next_pc)
               || (got.halted        !== exp.halted)
               || (got.reg_written   !== exp.reg_written)
               || (got.written_reg   !== exp.written_reg)
               || (got.written_value !== exp.written_value)
               || (got.zero_flag     !== exp.zero_flag)
               || (got.less_flag     !== exp.less_flag);
            if (bad) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("ERROR: exp pc=%0d hlt=%0b wr=%0b r%0d=%h z=%0b lt=%0b",
                             exp.next_pc, exp.halted, exp.reg_written, exp.written_reg,
                             exp.written_value, exp.zero_flag, exp.less_flag);
                    $display("       got pc=%0d hlt=%0b wr=%0b r%0d=%h z=%0b lt=%0b",
                             got.next_pc, got.halted, got.reg_written, got.written_reg,
                             got.written_value, got.zero_flag, got.less_flag);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    trm_stream_if #(.t_payload(t_trm_instr))  instr_if ();
    trm_stream_if #(.t_payload(t_trm_result)) result_if ();

    tiny_register_machine_step #(
        .PROGRAM_DEPTH  (PROGRAM_DEPTH),
        .REGISTER_COUNT (REGISTER_COUNT)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_instr  (instr_if.sink),
        .o_result (result_if.source)
    );

    machine_shadow shadow = new();

    // Gap control: idle_on and stall_on switch in stretches; steady turns
    // every gap off for the closing part of the run.
    bit idle_on;
    bit stall_on;
    bit steady;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the handshake locks up.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Result side: hold ready high, drop it in short random bursts.
    initial begin
        result_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!steady && stall_on && $urandom_range(0, 4) == 0) begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                result_if.ready <= 1'b1;
            end
        end
    end

    // Check every result word accepted at an edge outside reset.
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready)
            shadow.check_result(result_if.data);
    end

    function automatic t_trm_instr make_instr(logic [KIND_W-1:0] kind,
                                              logic [RIDX_W-1:0] dst,
                                              logic sir,
                                              logic [RIDX_W-1:0] src,
                                              logic [DATA_W-1:0] imm,
                                              logic [TARGET_W-1:0] tgt);
        t_trm_instr w;
        w.kind       = kind;
        w.dest_reg   = dst;
        w.src_is_reg = sir;
        w.src_reg    = src;
        w.immediate  = imm;
        w.target     = tgt;
        return w;
    endfunction

    // Build a well-formed random instruction: keep the counter below the end
    // of the program and steer operands so compares hit equal, near and far.
    function automatic t_trm_instr random_instr();
        t_trm_instr  w;
        int unsigned pick;
        w.dest_reg   = RIDX_W'($urandom_range(0, 7));
        w.src_is_reg = 1'($urandom_range(0, 1));
        w.src_reg    = RIDX_W'($urandom_range(0, 7));
        w.target     = TARGET_W'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0:       w.immediate = 32'h7FFF_FFFF;
            1:       w.immediate = 32'h8000_0000;
            2:       w.immediate = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            3:       w.immediate = shadow.read_reg(w.dest_reg);
            4:       w.immediate = shadow.read_reg(w.dest_reg)
                                   + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
            default: w.immediate = $urandom;
        endcase
        pick = $urandom_range(0, 99);
        if (shadow.pc >= PC_WRAP_LEVEL)
            w.kind = K_JMP;
        else if (pick < 14)
            w.kind = K_MOVE;
        else if (pick < 28)
            w.kind = K_ADD;
        else if (pick < 42)
            w.kind = K_SUB;
        else if (pick < 60)
            w.kind = K_CMP;
        else if (pick < 84)
            w.kind = KIND_W'($urandom_range(K_BNE, K_BGE));
        else if (pick < 92)
            w.kind = K_JMP;
        else
            w.kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        return w;
    endfunction

    // Present one word, wait for the handshake, note it, then maybe idle.
    // Valid stays high between back-to-back words.
    task automatic send_instr(t_trm_instr w);
        instr_if.valid <= 1'b1;
        instr_if.data  <= w;
        do @(posedge i_clk); while (!instr_if.ready);
        shadow.note_instr(w);
        if (!steady && idle_on && $urandom_range(0, 3) == 0) begin
            instr_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Drop valid and hold until every owed result word has come back.
    task automatic drain_results();
        instr_if.valid <= 1'b0;
        do @(posedge i_clk); while (shadow.owed_results.size() != 0);
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        instr_if.valid <= 1'b0;
        instr_if.data  <= '0;
        idle_on  = 1'b1;
        stall_on = 1'b1;
        steady   = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: operand extremes, wrapping add and subtract, register and
        // immediate sources, all three compare outcomes, every branch both
        // taken and not taken, jump to both ends, and the spare kinds.
        send_instr(make_instr(K_MOVE, 3'd7, 1'b0, 3'd7, 32'h7FFF_FFFF, 8'hFF));
        send_instr(make_instr(K_MOVE, 3'd0, 1'b0, 3'd0, 32'h8000_0000, 8'h00));
        send_instr(make_instr(K_ADD,  3'd7, 1'b0, 3'd0, 32'h0000_0001, 8'h00));
        send_instr(make_instr(K_SUB,  3'd0, 1'b0, 3'd0, 32'h0000_0001, 8'h00));
        send_instr(make_instr(K_MOVE, 3'd1, 1'b1, 3'd0, 32'hFFFF_FFFF, 8'hFF));
        send_instr(make_instr(K_CMP,  3'd7, 1'b1, 3'd0, 32'h0, 8'h00));
        send_instr(make_instr(K_BLT,  3'd0, 1'b0, 3'd0, 32'h0, 8'd20));
        send_instr(make_instr(K_BGE,  3'd0, 1'b0, 3'd0, 32'h0, 8'd0));
        send_instr(make_instr(K_BNE,  3'd0, 1'b0, 3'd0, 32'h0, 8'd40));
        send_instr(make_instr(K_BEQ,  3'd0, 1'b0, 3'd0, 32'h0, 8'd255));
        send_instr(make_instr(K_CMP,  3'd0, 1'b1, 3'd1, 32'h0, 8'h00));
        send_instr(make_instr(K_BEQ,  3'd0, 1'b0, 3'd0, 32'h0, 8'd60));
        send_instr(make_instr(K_BNE,  3'd0, 1'b0, 3'd0, 32'h0, 8'd0));
        send_instr(make_instr(K_BGE,  3'd0, 1'b0, 3'd0, 32'h0, 8'd100));
        send_instr(make_instr(K_BLT,  3'd0, 1'b0, 3'd0, 32'h0, 8'd200));
        send_instr(make_instr(K_CMP,  3'd0, 1'b0, 3'd0, 32'h8000_0000, 8'h00));
        send_instr(make_instr(K_SUB,  3'd2, 1'b1, 3'd7, 32'h0, 8'h00));
        send_instr(make_instr(K_ADD,  3'd3, 1'b0, 3'd0, 32'hFFFF_FFFF, 8'h00));
        send_instr(make_instr(K_CMP,  3'd3, 1'b0, 3'd0, 32'h0, 8'h00));
        send_instr(make_instr(KIND_SPARE_HI, 3'd7, 1'b1, 3'd7, 32'hFFFF_FFFF, 8'hFF));
        send_instr(make_instr(KIND_SPARE_LO, 3'd0, 1'b0, 3'd0, 32'h0, 8'h00));
        send_instr(make_instr(K_JMP,  3'd0, 1'b0, 3'd0, 32'h0, 8'd255));
        send_instr(make_instr(K_JMP,  3'd0, 1'b0, 3'd0, 32'h0, 8'd0));
        send_instr(make_instr(K_ADD,  3'd5, 1'b1, 3'd5, 32'h0, 8'h00));

        // Let the pipeline empty once before the random part.
        drain_results();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 100 == 0) begin
                idle_on  = ($urandom_range(0, 2) != 0);
                stall_on = ($urandom_range(0, 2) != 0);
            end
            if (n == RANDOM_WORDS / 2) drain_results();
            if (n == RANDOM_WORDS - STEADY_WORDS) steady = 1'b1;
            send_instr(random_instr());
        end

        // Stop the machine: either run off the end of the program or hit an
        // end instruction, then feed words that a halted machine must ignore.
        if ($urandom_range(0, 1)) begin
            send_instr(make_instr(K_JMP, 3'd0, 1'b0, 3'd0, 32'h0, 8'd255));
            send_instr(make_instr(K_ADD, 3'd6, 1'b0, 3'd0, 32'h1234_5678, 8'h00));
        end else begin
            send_instr(make_instr(K_END, 3'd6, 1'b0, 3'd0, 32'h1234_5678, 8'h00));
        end
        send_instr(make_instr(K_MOVE, 3'd4, 1'b0, 3'd0, 32'hDEAD_BEEF, 8'h00));
        send_instr(make_instr(K_END,  3'd0, 1'b0, 3'd0, 32'h0, 8'h00));
        send_instr(make_instr(K_JMP,  3'd0, 1'b0, 3'd0, 32'h0, 8'd7));
        repeat (3) send_instr(random_instr());

        drain_results();
        repeat (4) @(posedge i_clk);

        if (shadow.mismatches == 0 && shadow.owed_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
